/* rtl/bde_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bde_pkg
// Shared constants and types of the bounded deque engine.
// ----------------------------------------------------------------------------
package bde_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int DATA_W    = 32;
  localparam int OP_W      = 3;
  localparam int ST_W      = 2;
  localparam int LEN_W     = 5;

  // opcodes
  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEAR      = 3'd4;
  localparam logic [OP_W-1:0] OP_DUMP       = 3'd5;

  // result status codes
  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

  // controller -> datapath
  typedef struct packed {
    logic accept;      // item taken this cycle
    logic dump_begin;  // clear dump index
    logic rd_en;       // read ring at front + index
    logic emit_elem;   // load read word into output, advance index
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_free;    // output register can take a result
    logic empty;       // no stored elements
    logic idx_last;    // dump index points at the back element
  } sts_t;

endpackage

/* rtl/bounded_deque_engine_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_deque_engine_unit
// Bounded double-ended queue of signed 32-bit words held in a ring store.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one item: opcode_i and
//   value_i. Opcodes: push front, push back, pop front, pop back, clear, dump.
//   Output channel (out_valid_o / out_ready_i) carries results: element_o,
//   status_o (ok / empty / full), length_o (count after the op), last_o.
//   Push, pop, clear and an empty dump give one result, registered, in the
//   cycle after the item is taken; the next item can be taken in the very
//   cycle that result leaves, so these ops run at one item per cycle while
//   the receiver takes every result. Opcodes 6 and 7 give no result and are
//   taken one per cycle as well while the output register is free. A dump
//   walks the ring through its single read port: each element is read, then
//   loaded into the output register once that is free, with the input held
//   off until the walk ends. Results come front to back, last_o set on the back element.
//   Reset clears the front index, count, dump index and output valid; the store itself
//   is not cleared, only live entries are ever read.
//   When the receiver stalls, the result sits in the output register and
//   the input stops accepting until that register frees up.
// ----------------------------------------------------------------------------
module bounded_deque_engine_unit import bde_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [OP_W-1:0]          opcode_i,
  input  logic signed [DATA_W-1:0] value_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [DATA_W-1:0] element_o,
  output logic [ST_W-1:0]          status_o,
  output logic [LEN_W-1:0]         length_o,
  output logic                     last_o
);

  cmd_t cmd;
  sts_t sts;

  // sequencer: decides when an item is taken and steps the dump walk
  bde_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .opcode_i   (opcode_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // ring store, indices and the output register
  bde_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .opcode_i    (opcode_i),
    .value_i     (value_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .element_o   (element_o),
    .status_o    (status_o),
    .length_o    (length_o),
    .last_o      (last_o)
  );

endmodule

/* rtl/bde_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bde_ctrl
// Sequencer: input handshake and dump walk over the ring store.
// ----------------------------------------------------------------------------
module bde_ctrl import bde_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic [OP_W-1:0] opcode_i,
  output logic            in_ready_o,
  input  sts_t            sts_i,
  output cmd_t            cmd_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  logic [1:0] state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE) && sts_i.out_free;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        cmd_o.accept = in_valid_i && in_ready_o;
        if (cmd_o.accept && (opcode_i == OP_DUMP) && !sts_i.empty) begin
          cmd_o.dump_begin = 1'b1;
          state_d          = S_READ;
        end
      end
      S_READ: begin
        cmd_o.rd_en = 1'b1;
        state_d     = S_EMIT;
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit_elem = 1'b1;
          state_d         = sts_i.idx_last ? S_IDLE : S_READ;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* rtl/bde_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bde_dp
// Datapath: ring store, front index, count, dump index, output register.
// ----------------------------------------------------------------------------
module bde_dp import bde_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [OP_W-1:0]          opcode_i,
  input  logic signed [DATA_W-1:0] value_i,
  input  cmd_t                     cmd_i,
  output sts_t                     sts_o,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [DATA_W-1:0] element_o,
  output logic [ST_W-1:0]          status_o,
  output logic [LEN_W-1:0]         length_o,
  output logic                     last_o
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rd_data_q;

  logic [IW-1:0] front_q, front_d;
  logic [CW-1:0] count_q, count_d;
  logic [IW-1:0] idx_q, idx_d;

  logic                     out_valid_q, out_valid_d;
  logic signed [DATA_W-1:0] element_q, element_d;
  logic [ST_W-1:0]          status_q, status_d;
  logic [LEN_W-1:0]         length_q, length_d;
  logic                     last_q, last_d;

  logic          full, empty;
  logic [IW-1:0] front_dec, front_inc;
  logic [CW:0]   back_sum;
  logic [IW-1:0] back_addr;
  logic [IW:0]   rd_sum;
  logic [IW-1:0] rd_addr;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  logic [CW+LEN_W-1:0] len_new_ext, len_cur_ext;

  assign full  = (count_q == CW'(DEPTH));
  assign empty = (count_q == '0);

  assign front_dec = (front_q == '0) ? IW'(DEPTH - 1) : front_q - IW'(1);
  assign front_inc = (front_q == IW'(DEPTH - 1)) ? '0 : front_q + IW'(1);

  // back slot = (front + count) mod DEPTH, sum stays below 2*DEPTH
  assign back_sum  = (CW+1)'(front_q) + (CW+1)'(count_q);
  assign back_addr = (back_sum >= (CW+1)'(DEPTH)) ? IW'(back_sum - (CW+1)'(DEPTH))
                                                  : IW'(back_sum);

  assign rd_sum  = (IW+1)'(front_q) + (IW+1)'(idx_q);
  assign rd_addr = (rd_sum >= (IW+1)'(DEPTH)) ? IW'(rd_sum - (IW+1)'(DEPTH))
                                              : IW'(rd_sum);

  assign len_new_ext = (CW+LEN_W)'(count_d);
  assign len_cur_ext = (CW+LEN_W)'(count_q);

  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign sts_o.empty    = empty;
  assign sts_o.idx_last = ((CW'(idx_q) + CW'(1)) == count_q);

  always_comb begin
    front_d     = front_q;
    count_d     = count_q;
    idx_d       = idx_q;
    wr_en       = 1'b0;
    wr_addr     = back_addr;
    out_valid_d = out_valid_q && !out_ready_i;
    element_d   = element_q;
    status_d    = status_q;
    length_d    = length_q;
    last_d      = last_q;

    if (cmd_i.accept) begin
      element_d = '0;
      status_d  = ST_OK;
      last_d    = 1'b1;
      case (opcode_i)
        OP_PUSH_FRONT: begin
          if (full) begin
            status_d = ST_FULL;
          end else begin
            front_d = front_dec;
            wr_en   = 1'b1;
            wr_addr = front_dec;
            count_d = count_q + CW'(1);
          end
        end
        OP_PUSH_BACK: begin
          if (full) begin
            status_d = ST_FULL;
          end else begin
            wr_en   = 1'b1;
            count_d = count_q + CW'(1);
          end
        end
        OP_POP_FRONT: begin
          if (empty) begin
            status_d = ST_EMPTY;
          end else begin
            front_d = front_inc;
            count_d = count_q - CW'(1);
          end
        end
        OP_POP_BACK: begin
          if (empty) begin
            status_d = ST_EMPTY;
          end else begin
            count_d = count_q - CW'(1);
          end
        end
        OP_CLEAR: begin
          if (empty) status_d = ST_EMPTY;
          count_d = '0;
        end
        OP_DUMP: begin
          if (empty) status_d = ST_EMPTY;
        end
        default: begin
        end
      endcase
      length_d = len_new_ext[LEN_W-1:0];
      // unused opcodes and a non-empty dump give no result here
      if ((opcode_i <= OP_CLEAR) || ((opcode_i == OP_DUMP) && empty)) begin
        out_valid_d = 1'b1;
      end
    end

    if (cmd_i.dump_begin) idx_d = '0;

    if (cmd_i.emit_elem) begin
      out_valid_d = 1'b1;
      element_d   = rd_data_q;
      status_d    = ST_OK;
      length_d    = len_cur_ext[LEN_W-1:0];
      last_d      = sts_o.idx_last;
      idx_d       = idx_q + IW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_addr] <= value_i;
    if (cmd_i.rd_en) rd_data_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q     <= '0;
      count_q     <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      front_q     <= front_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    element_q <= element_d;
    status_q  <= status_d;
    length_q  <= length_d;
    last_q    <= last_d;
  end

  assign out_valid_o = out_valid_q;
  assign element_o   = element_q;
  assign status_o    = status_q;
  assign length_o    = length_q;
  assign last_o      = last_q;

endmodule

/* rtl/bde_chk.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bde_chk
// Port-level checks on the deque engine, bound to the top level.
// ----------------------------------------------------------------------------
module bde_chk import bde_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_ready_o,
  input logic                     out_valid_o,
  input logic                     out_ready_i,
  input logic signed [DATA_W-1:0] element_o,
  input logic [ST_W-1:0]          status_o,
  input logic [LEN_W-1:0]         length_o,
  input logic                     last_o
);

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(element_o)
      && $stable(status_o) && $stable(length_o) && $stable(last_o))
    else $error("result changed while stalled");

  // empty status always reports a zero length and zero element
  a_empty_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_EMPTY) |-> (length_o == '0) && (element_o == '0)
      && last_o)
    else $error("empty status with nonzero length");

  // full status only with the store at capacity
  a_full_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_FULL) |-> (length_o == LEN_W'(DEPTH)) && last_o)
    else $error("full status with wrong length");

  // a non-final result only comes from a dump walk
  a_mid_dump: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> (status_o == ST_OK) && (length_o != '0 || DEPTH > 31))
    else $error("unexpected non-final result");

  // while a dump is still mid-walk the input stays closed
  a_no_take_mid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_o |-> !in_ready_o)
    else $error("item taken during dump");

endmodule

bind bounded_deque_engine_unit bde_chk #(
  .DEPTH (DEPTH)
) u_bde_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .element_o   (element_o),
  .status_o    (status_o),
  .length_o    (length_o),
  .last_o      (last_o)
);

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the bounded deque engine: a software mirror of the
// deque predicts every result, and a monitor checks results in arrival order
// under random sender gaps, receiver stalls and one long output hold-off.
// ----------------------------------------------------------------------------
module tb;
  import bde_pkg::*;

  localparam int DEPTH         = DEPTH_DEF;
  localparam int HOLD_CYCLES   = 80;
  localparam int RANDOM_ITEMS  = 230;
  localparam int DRAIN_LIMIT   = 20000;
  localparam int TAIL_CYCLES   = 4 * DEPTH + 8;
  localparam int TIMEOUT_NS    = 5_000_000;

  // opcodes the block must ignore without producing a result
  localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

  localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;

  typedef struct packed {
    logic signed [DATA_W-1:0] element;
    logic [ST_W-1:0]          status;
    logic [LEN_W-1:0]         length;
    logic                     last;
  } deque_result_t;

  // DUT ports
  logic                     clk_i;
  logic                     rst_ni;
  logic                     in_valid_i;
  logic                     in_ready_o;
  logic [OP_W-1:0]          opcode_i;
  logic signed [DATA_W-1:0] value_i;
  logic                     out_valid_o;
  logic                     out_ready_i;
  logic signed [DATA_W-1:0] element_o;
  logic [ST_W-1:0]          status_o;
  logic [LEN_W-1:0]         length_o;
  logic                     last_o;

  // deque mirror
  logic signed [DATA_W-1:0] mirror_ring [DEPTH];
  int                       mirror_head;
  int                       mirror_count;
  deque_result_t            pending_results [$];

  // sender pacing
  int burst_left;
  bit steady_send;

  // receiver long hold-off handshake between main flow and receiver
  int stall_requests;
  int stall_served;
  int hold_left;
  int rx_mode;
  int rx_mode_left;
  int rx_phase;

  // bookkeeping
  int mismatches;
  int results_checked;
  int items_sent;
  int op_count [8];
  int full_hits;
  int empty_hits;
  int max_dump_len;

  bounded_deque_engine_unit #(
    .DEPTH(DEPTH)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .opcode_i   (opcode_i),
    .value_i    (value_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .element_o  (element_o),
    .status_o   (status_o),
    .length_o   (length_o),
    .last_o     (last_o)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  function automatic void flag_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
  endfunction

  // Applies one accepted item to the mirror and queues the results it causes.
  function automatic void predict_deque_results(input logic [OP_W-1:0] op,
                                                input logic signed [DATA_W-1:0] val);
    deque_result_t r;
    int            k;
    r.element = '0;
    r.status  = ST_OK;
    r.length  = '0;
    r.last    = 1'b1;
    case (op)
      OP_PUSH_FRONT: begin
        if (mirror_count >= DEPTH) begin
          r.status = ST_FULL;
          full_hits++;
        end else begin
          mirror_head = (mirror_head + DEPTH - 1) % DEPTH;
          mirror_ring[mirror_head] = val;
          mirror_count++;
        end
      end
      OP_PUSH_BACK: begin
        if (mirror_count >= DEPTH) begin
          r.status = ST_FULL;
          full_hits++;
        end else begin
          mirror_ring[(mirror_head + mirror_count) % DEPTH] = val;
          mirror_count++;
        end
      end
      OP_POP_FRONT: begin
        if (mirror_count == 0) begin
          r.status = ST_EMPTY;
          empty_hits++;
        end else begin
          mirror_head = (mirror_head + 1) % DEPTH;
          mirror_count--;
        end
      end
      OP_POP_BACK: begin
        if (mirror_count == 0) begin
          r.status = ST_EMPTY;
          empty_hits++;
        end else begin
          mirror_count--;
        end
      end
      OP_CLEAR: begin
        if (mirror_count == 0) begin
          r.status = ST_EMPTY;
          empty_hits++;
        end
        mirror_count = 0;
      end
      OP_DUMP: begin
        if (mirror_count == 0) begin
          r.status = ST_EMPTY;
          empty_hits++;
          pending_results.push_back(r);
          return;
        end
        if (mirror_count > max_dump_len) max_dump_len = mirror_count;
        for (k = 0; k < mirror_count; k++) begin
          r.element = mirror_ring[(mirror_head + k) % DEPTH];
          r.status  = ST_OK;
          r.length  = LEN_W'(mirror_count);
          r.last    = (k == mirror_count - 1);
          pending_results.push_back(r);
        end
        return;
      end
      default: return;  // spare opcodes: no state change, no result
    endcase
    r.length = LEN_W'(mirror_count);
    pending_results.push_back(r);
  endfunction

  // Offers one item, holding valid and payload until taken. Between bursts
  // the sender drops valid for a random stretch unless steady_send is set.
  task automatic send_item(input logic [OP_W-1:0] op,
                           input logic signed [DATA_W-1:0] val);
    if (!steady_send && burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40)
                                               : $urandom_range(1, 10);
    end
    in_valid_i <= 1'b1;
    opcode_i   <= op;
    value_i    <= val;
    do @(posedge clk_i); while (!in_ready_o);
    predict_deque_results(op, val);
    items_sent++;
    op_count[op]++;
    if (burst_left > 0) burst_left--;
  endtask

  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return VAL_MIN;
      1:       return VAL_MAX;
      2:       return -1;
      3:       return 0;
      4, 5:    return $urandom_range(0, 200) - 100;
      default: return $urandom;
    endcase
  endfunction

  // Empty-queue corners and the ignored opcodes.
  task automatic test_empty_corners();
    send_item(OP_POP_FRONT, VAL_MAX);
    send_item(OP_POP_BACK, VAL_MIN);
    send_item(OP_CLEAR, -1);
    send_item(OP_DUMP, 0);
    send_item(OP_SPARE_6, 32'sh5a5a_5a5a);
    send_item(OP_SPARE_7, 32'sh0f0f_0f0f);
  endtask

  // Fill from both ends with extreme values, overflow at both ends, dump a
  // full ring that has wrapped, then empty it again.
  task automatic test_fill_and_overflow();
    int n;
    for (n = 0; n < DEPTH; n++) begin
      case (n % 4)
        0:       send_item(OP_PUSH_FRONT, VAL_MIN);
        1:       send_item(OP_PUSH_BACK, VAL_MAX);
        2:       send_item(OP_PUSH_FRONT, -1);
        default: send_item(OP_PUSH_BACK, $urandom);
      endcase
    end
    send_item(OP_PUSH_FRONT, 32'sh1234_5678);
    send_item(OP_PUSH_BACK, 32'sh8765_4321);
    send_item(OP_DUMP, 0);
    send_item(OP_POP_FRONT, 0);
    send_item(OP_POP_BACK, 0);
    send_item(OP_CLEAR, 0);
    send_item(OP_DUMP, 0);
  endtask

  // Receiver holds off for a long stretch while the sender keeps offering
  // back-to-back items, so the block backs up and stalls its input.
  task automatic test_backpressure();
    int n;
    steady_send = 1'b1;
    stall_requests++;
    for (n = 0; n < 10; n++) begin
      send_item((n % 2) ? OP_PUSH_BACK : OP_PUSH_FRONT, pick_value());
    end
    send_item(OP_DUMP, 0);
    send_item(OP_POP_BACK, 0);
    send_item(OP_DUMP, 0);
    send_item(OP_CLEAR, 0);
    steady_send = 1'b0;
  endtask

  // Random traffic that swings between growing and shrinking the queue so
  // that both the full and empty boundaries are hit many times.
  task automatic test_random_mix();
    int               taken;
    int               trend_left;
    bit               growing;
    int unsigned      roll;
    int unsigned      push_w;
    logic [OP_W-1:0]  op;
    taken      = 0;
    trend_left = 0;
    growing    = 1'b1;
    while (taken < RANDOM_ITEMS) begin
      if (trend_left == 0) begin
        growing    = !growing;
        trend_left = $urandom_range(8, 30);
      end
      trend_left--;
      push_w = growing ? 72 : 15;
      roll   = $urandom_range(0, 99);
      if (roll < push_w) begin
        op = $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
      end else if (roll < 84) begin
        op = $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
      end else if (roll < 94) begin
        op = OP_DUMP;
      end else if (roll < 96) begin
        op = OP_CLEAR;
      end else begin
        op = $urandom_range(0, 1) ? OP_SPARE_7 : OP_SPARE_6;
      end
      send_item(op, ($urandom_range(0, 3) == 0) ? pick_value() : $urandom);
      if (op != OP_SPARE_6 && op != OP_SPARE_7) taken++;
    end
  endtask

  // Receiver: switches among stall patterns; a long hold-off takes priority
  // whenever the main flow requests one.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      stall_served = 0;
      hold_left    = 0;
      rx_mode      = 0;
      rx_mode_left = 0;
      rx_phase     = 0;
    end else if (stall_served != stall_requests) begin
      stall_served = stall_requests;
      hold_left    = HOLD_CYCLES - 1;
      out_ready_i <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode      = $urandom_range(0, 3);
        rx_mode_left = $urandom_range(10, 60);
      end
      rx_mode_left--;
      rx_phase++;
      case (rx_mode)
        0:       out_ready_i <= 1'b1;                          // no stalls
        1:       out_ready_i <= $urandom_range(0, 1);          // coin flip
        2:       out_ready_i <= (rx_phase % 4 == 0);           // one in four
        default: out_ready_i <= ($urandom_range(0, 4) != 0);   // light stalls
      endcase
    end
  end

  // Result monitor: every accepted result must match the oldest prediction.
  always @(posedge clk_i) begin
    deque_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_checked++;
      if (pending_results.size() == 0) begin
        flag_mismatch($sformatf("unexpected result elem=%0d st=%0d len=%0d last=%0b",
                                element_o, status_o, length_o, last_o));
      end else begin
        want = pending_results.pop_front();
        if (element_o !== want.element || status_o !== want.status ||
            length_o !== want.length || last_o !== want.last) begin
          flag_mismatch($sformatf(
            "exp elem=%0d st=%0d len=%0d last=%0b, got elem=%0d st=%0d len=%0d last=%0b",
            want.element, want.status, want.length, want.last,
            element_o, status_o, length_o, last_o));
        end
      end
    end
  end

  initial begin
    #TIMEOUT_NS;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    int guard;
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    opcode_i    <= OP_PUSH_FRONT;
    value_i     <= '0;
    mirror_head     = 0;
    mirror_count    = 0;
    burst_left      = 0;
    steady_send     = 1'b0;
    stall_requests  = 0;
    mismatches      = 0;
    results_checked = 0;
    items_sent      = 0;
    full_hits       = 0;
    empty_hits      = 0;
    max_dump_len    = 0;
    foreach (op_count[i]) op_count[i] = 0;
    foreach (mirror_ring[i]) mirror_ring[i] = '0;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_corners();
    test_fill_and_overflow();
    test_backpressure();
    test_random_mix();
    in_valid_i <= 1'b0;

    // drain, then give a straggler time to show up
    guard = 0;
    while (pending_results.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk_i);
      guard++;
    end
    if (pending_results.size() != 0) begin
      flag_mismatch($sformatf("%0d results never arrived", pending_results.size()));
    end
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Sent %0d items: push f/b %0d/%0d, pop f/b %0d/%0d, clear %0d, dump %0d, spare %0d",
             items_sent, op_count[OP_PUSH_FRONT], op_count[OP_PUSH_BACK],
             op_count[OP_POP_FRONT], op_count[OP_POP_BACK], op_count[OP_CLEAR],
             op_count[OP_DUMP], op_count[OP_SPARE_6] + op_count[OP_SPARE_7]);
    $display("Checked %0d results; full drops %0d, empty reports %0d, longest dump %0d, %0d mismatches",
             results_checked, full_hits, empty_hits, max_dump_len, mismatches);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* bounded_deque_engine_unit.f */
rtl/bde_pkg.sv
rtl/bde_ctrl.sv
rtl/bde_dp.sv
rtl/bounded_deque_engine_unit.sv
rtl/bde_chk.sv
tb/tb.sv
